[hdl/volume_gradient_normal_macros.svh]
// Assertion helpers used by the checker file.
`ifndef VOLUME_GRADIENT_NORMAL_MACROS_SVH
`define VOLUME_GRADIENT_NORMAL_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define VGN_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define VGN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/vgn_pkg.sv]
`timescale 1ns / 1ps

package vgn_pkg;

    localparam int VOLUME_DIM = 256;
    localparam int COORD_W    = 8;
    localparam int VAL_W      = 8;
    localparam int DIM_BITS   = $clog2(VOLUME_DIM);
    localparam int ADDR_W     = 3 * DIM_BITS;
    localparam int RAM_DEPTH  = 2 ** ADDR_W;

    // gradient datapath widths
    localparam int A_W   = 17;  // (255-z)*l + z*h
    localparam int D_W   = 9;   // h - l
    localparam int G_W   = 22;  // signed gradient component
    localparam int MAG_W = 21;  // |gradient component|
    localparam int UU_W  = 29;  // 254 * |g|
    localparam int S_W   = 42;  // sum of squares
    localparam int P_W   = 58;  // widest product kept
    localparam int MB_W  = 32;  // multiplier B operand
    localparam int MSTEP_W = 8; // B bits consumed per cycle
    localparam int MCNT_W  = $clog2(MB_W / MSTEP_W);

    localparam logic [7:0] NORM_MID  = 8'd127;
    localparam logic [7:0] R_MAX     = 8'd254;
    localparam logic [8:0] T_OFFSET  = 9'd255;
    localparam logic [UU_W-1:0] UU_SCALE = UU_W'(254);

    localparam logic [1:0] KIND_WRITE    = 2'd0;
    localparam logic [1:0] KIND_SKIP     = 2'd1;
    localparam logic [1:0] KIND_BORDER   = 2'd2;
    localparam logic [1:0] KIND_INTERIOR = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [VAL_W-1:0]   value;
    } item_t;

    typedef struct packed {
        logic            start;
        logic [S_W-1:0]  a;
        logic [MB_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic           done;
        logic [P_W-1:0] product;
    } mul_rsp_t;

    // 5,12,5 smoothing across the gradient direction
    function automatic logic [3:0] side_weight(input logic [1:0] idx);
        side_weight = (idx == 2'd1) ? 4'd12 : 4'd5;
    endfunction

    // depth kernel, already doubled: 2*(1,3,1, 3,6,3, 1,3,1)
    function automatic logic [3:0] depth_weight(input logic [1:0] row, input logic [1:0] col);
        logic rc;
        logic cc;
        rc = (row == 2'd1);
        cc = (col == 2'd1);
        if (rc && cc)
            depth_weight = 4'd12;
        else if (rc || cc)
            depth_weight = 4'd6;
        else
            depth_weight = 4'd2;
    endfunction

endpackage

[hdl/volume_gradient_normal.sv]
`timescale 1ns / 1ps

// Voxel normal generator. Issue a transaction by raising start while busy is
// low: action 0 stores voxel_value at (pos_x,pos_y,pos_z), action 1 asks for
// the surface normal there. Each normal request returns exactly one result,
// marked by a one-cycle done strobe; stores return nothing. done cannot be
// held off, so capture normal_x/y/z and gradient_zero in the cycle it is
// high. Results come back in request order. Up to two transactions wait in
// the input queue; busy rises only when it is full. Interior requests are
// bound by the single voxel memory port (18 neighbor reads, one neighbor
// pair at a time with the gradient update) and by the shared byte-serial
// multiplier (one product at a time: 3 squares, then for each component one
// square of 254*|g| and an 8-step bitwise search of the rounded result).
// The voxel memory is not cleared after reset; requests must only touch
// voxels already stored.

module volume_gradient_normal (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       action,
    input  logic [7:0] pos_x,
    input  logic [7:0] pos_y,
    input  logic [7:0] pos_z,
    input  logic [7:0] voxel_value,
    output logic       done,
    output logic [7:0] normal_x,
    output logic [7:0] normal_y,
    output logic [7:0] normal_z,
    output logic       gradient_zero
);

    // front side: classify and queue transactions
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;
    vgn_pkg::item_t push_item;
    vgn_pkg::item_t head;

    // back side: voxel memory port
    logic                       ram_we;
    logic [vgn_pkg::ADDR_W-1:0] ram_addr;
    logic [vgn_pkg::VAL_W-1:0]  ram_wdata;
    logic [vgn_pkg::VAL_W-1:0]  ram_rdata;

    vgn_front u_front (
        .start       (start),
        .busy        (busy),
        .action      (action),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .voxel_value (voxel_value),
        .q_full      (q_full),
        .push        (push),
        .item        (push_item)
    );

    // short decoupling queue: front keeps accepting while back grinds
    vgn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    vgn_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_empty       (q_empty),
        .pop           (pop),
        .ram_we        (ram_we),
        .ram_addr      (ram_addr),
        .ram_wdata     (ram_wdata),
        .ram_rdata     (ram_rdata),
        .done          (done),
        .normal_x      (normal_x),
        .normal_y      (normal_y),
        .normal_z      (normal_z),
        .gradient_zero (gradient_zero)
    );

    // full-volume byte store, one port, registered read
    vgn_ram #(
        .WIDTH (vgn_pkg::VAL_W),
        .DEPTH (vgn_pkg::RAM_DEPTH)
    ) u_voxels (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule

[hdl/vgn_ram.sv]
`timescale 1ns / 1ps

module vgn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/vgn_mul.sv]
`timescale 1ns / 1ps

module vgn_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  vgn_pkg::mul_req_t req,
    output vgn_pkg::mul_rsp_t rsp
);

    logic                          run_reg, run_next;
    logic                          done_reg, done_next;
    logic [vgn_pkg::MCNT_W-1:0]    cnt_reg, cnt_next;
    logic [vgn_pkg::P_W-1:0]       a_reg, a_next;
    logic [vgn_pkg::MB_W-1:0]      b_reg, b_next;
    logic [vgn_pkg::P_W-1:0]       acc_reg, acc_next;
    logic [vgn_pkg::P_W-1:0]       partial;

    // one byte of B per cycle against the shifted A
    assign partial = vgn_pkg::P_W'(a_reg * b_reg[vgn_pkg::MSTEP_W-1:0]);

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            a_next   = vgn_pkg::P_W'(req.a);
            b_next   = req.b;
            acc_next = '0;
        end
        else if (run_reg)
        begin
            acc_next = acc_reg + partial;
            a_next   = a_reg << vgn_pkg::MSTEP_W;
            b_next   = b_reg >> vgn_pkg::MSTEP_W;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == {vgn_pkg::MCNT_W{1'b1}})
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

[hdl/vgn_front.sv]
`timescale 1ns / 1ps

module vgn_front (
    input  logic                         start,
    output logic                         busy,
    input  logic                         action,
    input  logic [vgn_pkg::COORD_W-1:0]  pos_x,
    input  logic [vgn_pkg::COORD_W-1:0]  pos_y,
    input  logic [vgn_pkg::COORD_W-1:0]  pos_z,
    input  logic [vgn_pkg::VAL_W-1:0]    voxel_value,
    input  logic                         q_full,
    output logic                         push,
    output vgn_pkg::item_t               item
);

    localparam logic [vgn_pkg::COORD_W:0] DIM_LIM  = (vgn_pkg::COORD_W + 1)'(vgn_pkg::VOLUME_DIM);
    localparam logic [vgn_pkg::COORD_W:0] EDGE_LIM = (vgn_pkg::COORD_W + 1)'(vgn_pkg::VOLUME_DIM - 1);

    logic outside;
    logic border;

    assign busy = q_full;
    assign push = start && !q_full;

    assign outside = ({1'b0, pos_x} >= DIM_LIM) || ({1'b0, pos_y} >= DIM_LIM) ||
                     ({1'b0, pos_z} >= DIM_LIM);
    assign border  = (pos_x == '0) || (pos_y == '0) || (pos_z == '0) ||
                     ({1'b0, pos_x} >= EDGE_LIM) || ({1'b0, pos_y} >= EDGE_LIM) ||
                     ({1'b0, pos_z} >= EDGE_LIM);

    always_comb
    begin
        item.x     = pos_x;
        item.y     = pos_y;
        item.z     = pos_z;
        item.value = voxel_value;
        if (!action)
            item.kind = outside ? vgn_pkg::KIND_SKIP : vgn_pkg::KIND_WRITE;
        else
            item.kind = border ? vgn_pkg::KIND_BORDER : vgn_pkg::KIND_INTERIOR;
    end

endmodule

[hdl/vgn_queue.sv]
`timescale 1ns / 1ps

module vgn_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  vgn_pkg::item_t push_item,
    input  logic           pop,
    output vgn_pkg::item_t head,
    output logic           full,
    output logic           empty
);

    vgn_pkg::item_t entries [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_item;
    end

endmodule

[hdl/vgn_back.sv]
`timescale 1ns / 1ps

module vgn_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  vgn_pkg::item_t                head,
    input  logic                          q_empty,
    output logic                          pop,
    output logic                          ram_we,
    output logic [vgn_pkg::ADDR_W-1:0]    ram_addr,
    output logic [vgn_pkg::VAL_W-1:0]     ram_wdata,
    input  logic [vgn_pkg::VAL_W-1:0]     ram_rdata,
    output logic                          done,
    output logic [7:0]                    normal_x,
    output logic [7:0]                    normal_y,
    output logic [7:0]                    normal_z,
    output logic                          gradient_zero
);

    localparam int DB = vgn_pkg::DIM_BITS;
    localparam int GW = vgn_pkg::G_W;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_WRITE     = 4'd1;
    localparam logic [3:0] S_RD_L      = 4'd2;
    localparam logic [3:0] S_RD_H      = 4'd3;
    localparam logic [3:0] S_CAP       = 4'd4;
    localparam logic [3:0] S_ACC       = 4'd5;
    localparam logic [3:0] S_CHECK     = 4'd6;
    localparam logic [3:0] S_SQ_GO     = 4'd7;
    localparam logic [3:0] S_SQ_WAIT   = 4'd8;
    localparam logic [3:0] S_UU_GO     = 4'd9;
    localparam logic [3:0] S_UU_WAIT   = 4'd10;
    localparam logic [3:0] S_STEP_GO   = 4'd11;
    localparam logic [3:0] S_STEP_WAIT = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       done_reg, done_next;

    logic [vgn_pkg::COORD_W-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [vgn_pkg::VAL_W-1:0]   val_reg, val_next;
    logic [1:0]                  row_reg, row_next, col_reg, col_next;
    logic [7:0]                  lo_reg, lo_next;
    logic [vgn_pkg::A_W-1:0]     a_reg, a_next;
    logic signed [vgn_pkg::D_W-1:0] d_reg, d_next;
    logic signed [GW-1:0]        gx_reg, gx_next, gy_reg, gy_next, gz_reg, gz_next;
    logic [vgn_pkg::S_W-1:0]     s_reg, s_next;
    logic [vgn_pkg::P_W-1:0]     uu2_reg, uu2_next;
    logic [1:0]                  comp_reg, comp_next;
    logic [7:0]                  r_reg, r_next;
    logic [2:0]                  bit_reg, bit_next;
    logic [7:0]                  rx_reg, rx_next, ry_reg, ry_next;
    logic [7:0]                  nx_reg, nx_next, ny_reg, ny_next, nz_reg, nz_next;
    logic                        gzero_reg, gzero_next;

    vgn_pkg::mul_req_t mreq;
    vgn_pkg::mul_rsp_t mrsp;

    logic [7:0] nb_x, nb_y, z_lo, z_hi;
    logic [15:0] pl, ph;
    logic [3:0] wsx, wsy, wdz;
    logic signed [GW-1:0] a_s, d_s, tx, ty, tz;
    logic signed [GW-1:0] g_sel;
    logic [vgn_pkg::MAG_W-1:0] mag;
    logic [vgn_pkg::UU_W-1:0]  uu;
    logic [7:0] cand;
    logic       over, tneg, gneg, take, step_adv, step_take;
    logic [8:0] t_raw;
    logic [7:0] tt;
    logic [15:0] tt2;
    logic [7:0] r_fin;

    vgn_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    // neighbor coordinates
    assign nb_x = x_reg + {6'b0, col_reg} - 8'd1;
    assign nb_y = y_reg + {6'b0, row_reg} - 8'd1;
    assign z_lo = z_reg - 8'd1;
    assign z_hi = z_reg + 8'd1;

    // depth blend of the two slices
    assign pl = {8'd0, 8'd255 - z_reg} * {8'd0, lo_reg};
    assign ph = z_reg * ram_rdata;

    assign wsx = vgn_pkg::side_weight(row_reg);
    assign wsy = vgn_pkg::side_weight(col_reg);
    assign wdz = vgn_pkg::depth_weight(row_reg, col_reg);
    assign a_s = GW'($signed({1'b0, a_reg}));
    assign d_s = GW'(d_reg);
    assign tx  = GW'($signed({1'b0, wsx})) * a_s;
    assign ty  = GW'($signed({1'b0, wsy})) * a_s;
    assign tz  = GW'($signed({1'b0, wdz})) * d_s;

    assign g_sel = (comp_reg == 2'd0) ? gx_reg : ((comp_reg == 2'd1) ? gy_reg : gz_reg);
    assign gneg  = g_sel[GW-1];
    assign mag   = vgn_pkg::MAG_W'(gneg ? -g_sel : g_sel);
    assign uu    = vgn_pkg::UU_W'(mag) * vgn_pkg::UU_SCALE;

    // candidate of the bitwise search and its (2r-255)^2
    assign cand  = r_reg | (8'd1 << bit_reg);
    assign over  = (cand > vgn_pkg::R_MAX);
    assign tneg  = !cand[7];
    assign t_raw = tneg ? (vgn_pkg::T_OFFSET - {cand, 1'b0}) : ({cand, 1'b0} - vgn_pkg::T_OFFSET);
    assign tt    = t_raw[7:0];
    assign tt2   = tt * tt;

    assign take = tneg ? (!gneg || (mrsp.product >= uu2_reg))
                       : (!gneg && (mrsp.product <= uu2_reg));
    assign step_adv  = ((state_reg == S_STEP_GO) && over) ||
                       ((state_reg == S_STEP_WAIT) && mrsp.done);
    assign step_take = (state_reg == S_STEP_WAIT) && take;
    assign r_fin     = step_take ? cand : r_reg;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        x_next = x_reg;  y_next = y_reg;  z_next = z_reg;  val_next = val_reg;
        row_next = row_reg;  col_next = col_reg;
        lo_next = lo_reg;  a_next = a_reg;  d_next = d_reg;
        gx_next = gx_reg;  gy_next = gy_reg;  gz_next = gz_reg;
        s_next = s_reg;  uu2_next = uu2_reg;  comp_next = comp_reg;
        r_next = r_reg;  bit_next = bit_reg;
        rx_next = rx_reg;  ry_next = ry_reg;
        nx_next = nx_reg;  ny_next = ny_reg;  nz_next = nz_reg;  gzero_next = gzero_reg;
        pop       = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = {z_reg[DB-1:0], y_reg[DB-1:0], x_reg[DB-1:0]};
        ram_wdata = val_reg;
        mreq.start = 1'b0;
        mreq.a     = vgn_pkg::S_W'(mag);
        mreq.b     = vgn_pkg::MB_W'(mag);

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    x_next   = head.x;
                    y_next   = head.y;
                    z_next   = head.z;
                    val_next = head.value;
                    case (head.kind)
                        vgn_pkg::KIND_WRITE:
                            state_next = S_WRITE;
                        vgn_pkg::KIND_BORDER:
                        begin
                            nx_next    = vgn_pkg::NORM_MID;
                            ny_next    = vgn_pkg::NORM_MID;
                            nz_next    = vgn_pkg::NORM_MID;
                            gzero_next = 1'b0;
                            done_next  = 1'b1;
                        end
                        vgn_pkg::KIND_INTERIOR:
                        begin
                            gx_next  = '0;
                            gy_next  = '0;
                            gz_next  = '0;
                            s_next   = '0;
                            row_next = 2'd0;
                            col_next = 2'd0;
                            state_next = S_RD_L;
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_WRITE:
            begin
                ram_we     = 1'b1;
                state_next = S_IDLE;
            end
            S_RD_L:
            begin
                ram_addr   = {z_lo[DB-1:0], nb_y[DB-1:0], nb_x[DB-1:0]};
                state_next = S_RD_H;
            end
            S_RD_H:
            begin
                ram_addr   = {z_hi[DB-1:0], nb_y[DB-1:0], nb_x[DB-1:0]};
                lo_next    = ram_rdata;
                state_next = S_CAP;
            end
            S_CAP:
            begin
                a_next     = vgn_pkg::A_W'(pl) + vgn_pkg::A_W'(ph);
                d_next     = $signed({1'b0, ram_rdata}) - $signed({1'b0, lo_reg});
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (col_reg == 2'd2)
                    gx_next = gx_reg + tx;
                else if (col_reg == 2'd0)
                    gx_next = gx_reg - tx;
                if (row_reg == 2'd2)
                    gy_next = gy_reg + ty;
                else if (row_reg == 2'd0)
                    gy_next = gy_reg - ty;
                gz_next = gz_reg + tz;
                if (col_reg == 2'd2)
                begin
                    col_next = 2'd0;
                    if (row_reg == 2'd2)
                        state_next = S_CHECK;
                    else
                    begin
                        row_next   = row_reg + 2'd1;
                        state_next = S_RD_L;
                    end
                end
                else
                begin
                    col_next   = col_reg + 2'd1;
                    state_next = S_RD_L;
                end
            end
            S_CHECK:
            begin
                comp_next = 2'd0;
                if ((gx_reg == '0) && (gy_reg == '0) && (gz_reg == '0))
                begin
                    nx_next    = 8'd0;
                    ny_next    = 8'd0;
                    nz_next    = 8'd0;
                    gzero_next = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_SQ_GO;
            end
            S_SQ_GO:
            begin
                mreq.start = 1'b1;
                state_next = S_SQ_WAIT;
            end
            S_SQ_WAIT:
            begin
                if (mrsp.done)
                begin
                    s_next = s_reg + vgn_pkg::S_W'(mrsp.product);
                    if (comp_reg == 2'd2)
                    begin
                        comp_next  = 2'd0;
                        state_next = S_UU_GO;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = S_SQ_GO;
                    end
                end
            end
            S_UU_GO:
            begin
                mreq.start = 1'b1;
                mreq.a     = vgn_pkg::S_W'(uu);
                mreq.b     = vgn_pkg::MB_W'(uu);
                state_next = S_UU_WAIT;
            end
            S_UU_WAIT:
            begin
                if (mrsp.done)
                begin
                    uu2_next   = mrsp.product;
                    r_next     = 8'd0;
                    bit_next   = 3'd7;
                    state_next = S_STEP_GO;
                end
            end
            S_STEP_GO:
            begin
                if (!over)
                begin
                    mreq.start = 1'b1;
                    mreq.a     = s_reg;
                    mreq.b     = vgn_pkg::MB_W'(tt2);
                    state_next = S_STEP_WAIT;
                end
            end
            S_STEP_WAIT:
            begin
                mreq.a = s_reg;
                mreq.b = vgn_pkg::MB_W'(tt2);
            end
            default:
                state_next = S_IDLE;
        endcase

        // advance the search by one bit, close the component after bit zero
        if (step_adv)
        begin
            r_next = r_fin;
            if (bit_reg == 3'd0)
            begin
                case (comp_reg)
                    2'd0:
                    begin
                        rx_next    = r_fin;
                        comp_next  = 2'd1;
                        state_next = S_UU_GO;
                    end
                    2'd1:
                    begin
                        ry_next    = r_fin;
                        comp_next  = 2'd2;
                        state_next = S_UU_GO;
                    end
                    default:
                    begin
                        nx_next    = rx_reg;
                        ny_next    = ry_reg;
                        nz_next    = r_fin;
                        gzero_next = 1'b0;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            else
            begin
                bit_next   = bit_reg - 3'd1;
                state_next = S_STEP_GO;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;  y_reg <= y_next;  z_reg <= z_next;  val_reg <= val_next;
        row_reg <= row_next;  col_reg <= col_next;
        lo_reg <= lo_next;  a_reg <= a_next;  d_reg <= d_next;
        gx_reg <= gx_next;  gy_reg <= gy_next;  gz_reg <= gz_next;
        s_reg <= s_next;  uu2_reg <= uu2_next;  comp_reg <= comp_next;
        r_reg <= r_next;  bit_reg <= bit_next;
        rx_reg <= rx_next;  ry_reg <= ry_next;
        nx_reg <= nx_next;  ny_reg <= ny_next;  nz_reg <= nz_next;
        gzero_reg <= gzero_next;
    end

    assign done          = done_reg;
    assign normal_x      = nx_reg;
    assign normal_y      = ny_reg;
    assign normal_z      = nz_reg;
    assign gradient_zero = gzero_reg;

endmodule

[hdl/vgn_checker.sv]
`timescale 1ns / 1ps
`include "volume_gradient_normal_macros.svh"

module vgn_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [7:0] normal_x,
    input logic [7:0] normal_y,
    input logic [7:0] normal_z,
    input logic       gradient_zero
);

    // a flat gradient reports all-zero components
    `VGN_ASSERT_IMPLIES(a_zero_grad, done && gradient_zero, (normal_x == 8'd0) && (normal_y == 8'd0) && (normal_z == 8'd0), "zero gradient with nonzero normal")

    // mapped components never reach 255
    `VGN_ASSERT_IMPLIES(a_range, done, (normal_x != 8'hFF) && (normal_y != 8'hFF) && (normal_z != 8'hFF), "normal component out of range")

    // leaving reset: queue empty, no result pending
    `VGN_ASSERT_IMPLIES(a_reset_quiet, !$past(rst_n), !busy && !done, "activity right after reset")

    // busy can only rise after a transaction was taken
    `VGN_ASSERT_NEXT(a_busy_cause, !start && !busy, !busy, "busy rose without a transaction")

endmodule

bind volume_gradient_normal vgn_checker u_vgn_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .normal_x      (normal_x),
    .normal_y      (normal_y),
    .normal_z      (normal_z),
    .gradient_zero (gradient_zero)
);

[tb/sv/tb_volume_gradient_normal.sv]
`timescale 1ns / 1ps

// Scoreboard for the voxel normal generator: mirrors the voxel store, works
// out the normal for every accepted compute transaction and checks the
// results in order.
class normal_scoreboard;
    bit [7:0] voxels [int];
    bit [24:0] pending [$];   // {gradient_zero, nx, ny, nz}
    int fails;

    function int vox_addr(int x, int y, int z);
        return (z << 16) | (y << 8) | x;
    endfunction

    // append one expected result at the tail
    function void expect_result(bit [24:0] w);
        pending.insert(pending.size(), w);
    endfunction

    // true when every voxel of slices z-1 and z+1 around (x,y) is written
    function bit ready(int x, int y, int z);
        for (int dz = -1; dz <= 1; dz += 2)
            for (int dy = -1; dy <= 1; dy++)
                for (int dx = -1; dx <= 1; dx++)
                    if (!voxels.exists(vox_addr(x + dx, y + dy, z + dz)))
                        return 0;
        return 1;
    endfunction

    // true when (2r-255)*sqrt(s) <= 254*g, decided on exact squares
    function bit fits(int r, longint g, longint unsigned s);
        longint t;
        longint u;
        longint unsigned tt;
        longint unsigned uu;
        t = 2 * r - 255;
        u = 254 * g;
        tt = (t < 0) ? -t : t;
        uu = (u < 0) ? -u : u;
        if (t == 0)
            return u >= 0;
        if (t < 0 && u >= 0)
            return 1;
        if (t > 0 && u < 0)
            return 0;
        if (t > 0)
            return tt * tt * s <= uu * uu;
        return tt * tt * s >= uu * uu;
    endfunction

    function bit [7:0] to_byte(longint g, longint unsigned s);
        int r;
        r = 254;
        while (r > 0 && !fits(r, g, s))
            r--;
        return r[7:0];
    endfunction

    function void note(bit act, int x, int y, int z, bit [7:0] val);
        longint lo, hi, d, gx, gy, gz;
        longint a [3][3];
        longint sw [3];
        longint unsigned s;
        if (act == 1'b0)
        begin
            voxels[vox_addr(x, y, z)] = val;
            return;
        end
        if (x == 0 || y == 0 || z == 0 || x >= 255 || y >= 255 || z >= 255)
        begin
            expect_result({1'b0, 8'd127, 8'd127, 8'd127});
            return;
        end
        sw = '{5, 12, 5};
        gx = 0;
        gy = 0;
        gz = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                lo = voxels[vox_addr(x + j - 1, y + i - 1, z - 1)];
                hi = voxels[vox_addr(x + j - 1, y + i - 1, z + 1)];
                d = hi - lo;
                a[i][j] = 255 * lo + z * d;
                // depth kernel 1,3,1 / 3,6,3 / 1,3,1
                gz += ((i == 1 && j == 1) ? 6 : (i == 1 || j == 1) ? 3 : 1) * d;
            end
        for (int i = 0; i < 3; i++)
        begin
            gx += sw[i] * (a[i][2] - a[i][0]);
            gy += sw[i] * (a[2][i] - a[0][i]);
        end
        gz *= 2;
        if (gx == 0 && gy == 0 && gz == 0)
        begin
            expect_result({1'b1, 24'd0});
            return;
        end
        s = gx * gx + gy * gy + gz * gz;
        expect_result({1'b0, to_byte(gx, s), to_byte(gy, s), to_byte(gz, s)});
    endfunction

    function void check(bit [7:0] nx, bit [7:0] ny, bit [7:0] nz, bit zero);
        bit [24:0] want;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result nx=%0d ny=%0d nz=%0d zero=%0b",
                     $time, nx, ny, nz, zero);
            fails++;
            return;
        end
        want = pending.pop_front();
        if (want[24] !== zero)
        begin
            $display("%0t: gradient_zero expected %0b actual %0b", $time, want[24], zero);
            fails++;
        end
        if (want[23:16] !== nx)
        begin
            $display("%0t: normal_x expected %0d actual %0d", $time, want[23:16], nx);
            fails++;
        end
        if (want[15:8] !== ny)
        begin
            $display("%0t: normal_y expected %0d actual %0d", $time, want[15:8], ny);
            fails++;
        end
        if (want[7:0] !== nz)
        begin
            $display("%0t: normal_z expected %0d actual %0d", $time, want[7:0], nz);
            fails++;
        end
    endfunction
endclass

module tb_volume_gradient_normal;

    localparam bit ACT_WRITE  = 1'b0;
    localparam bit ACT_NORMAL = 1'b1;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 400;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       action;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] pos_z;
    logic [7:0] voxel_value;
    logic       done;
    logic [7:0] normal_x;
    logic [7:0] normal_y;
    logic [7:0] normal_z;
    logic       gradient_zero;

    normal_scoreboard sb;
    int  sent;
    bit  calm;          // no idle gaps while set
    int  stall_cycles;
    int  centers_x [$];
    int  centers_y [$];
    int  centers_z [$];

    volume_gradient_normal uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .voxel_value(voxel_value),
        .done(done), .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .gradient_zero(gradient_zero)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Push one transaction: optionally idle first, hold it until busy is low
    // at a rising edge, then hand it to the scoreboard.
    task automatic send(bit act, int x, int y, int z, int val);
        if (!calm && $urandom_range(99) < 12)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        else
            @(negedge clk);
        start       <= 1'b1;
        action      <= act;
        pos_x       <= x[7:0];
        pos_y       <= y[7:0];
        pos_z       <= z[7:0];
        voxel_value <= val[7:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note(act, x, y, z, val[7:0]);
        sent++;
    endtask

    // Write both neighbor slices around a center, then ask for its normal.
    // flavor 0: uniform (zero gradient), 1: random bytes, 2: 0/255 only,
    // 3: small ripple around a base value.
    task automatic fill_and_compute(int x, int y, int z, int flavor);
        int base;
        int val;
        base = $urandom_range(0, 255);
        for (int dz = -1; dz <= 1; dz += 2)
            for (int dy = -1; dy <= 1; dy++)
                for (int dx = -1; dx <= 1; dx++)
                begin
                    case (flavor)
                        0: val = base;
                        1: val = $urandom_range(0, 255);
                        2: val = $urandom_range(1) ? 255 : 0;
                        default: val = (base + $urandom_range(0, 3)) & 8'hFF;
                    endcase
                    send(ACT_WRITE, x + dx, y + dy, z + dz, val);
                end
        send(ACT_NORMAL, x, y, z, $urandom_range(0, 255));
        centers_x.insert(centers_x.size(), x);
        centers_y.insert(centers_y.size(), y);
        centers_z.insert(centers_z.size(), z);
    endtask

    function automatic int pick_interior();
        case ($urandom_range(0, 5))
            0: return 1;
            1: return 254;
            default: return $urandom_range(1, 254);
        endcase
    endfunction

    // Track results and the no-progress watchdog.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check(normal_x, normal_y, normal_z, gradient_zero);
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("** volume_gradient_normal: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int k;
        int pick;
        sb = new();
        sent = 0;
        calm = 1'b0;
        stall_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_WRITE;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        voxel_value = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: volume corners, border requests on faces x=0, y=255, z=0 and
        // the far corner, and a uniform neighborhood that must report a zero gradient.
        send(ACT_WRITE, 255, 255, 255, 255);
        send(ACT_WRITE, 0, 0, 0, 0);
        send(ACT_NORMAL, 0, 9, 9, 0);
        send(ACT_NORMAL, 9, 255, 9, 255);
        send(ACT_NORMAL, 9, 9, 0, 0);
        send(ACT_NORMAL, 255, 255, 255, 0);
        fill_and_compute(5, 5, 5, 0);

        // Random: complete neighborhoods with random content, plus
        // rewrites of known neighborhoods, border requests and stray writes.
        while (sent < 400)
        begin
            calm = (sent >= 180 && sent < 260);
            pick = $urandom_range(0, 99);
            if (pick < 45 || centers_x.size() == 0)
                fill_and_compute(pick_interior(), pick_interior(), pick_interior(),
                                 $urandom_range(0, 3));
            else if (pick < 70)
            begin
                k = $urandom_range(0, centers_x.size() - 1);
                repeat ($urandom_range(1, 4))
                    send(ACT_WRITE, centers_x[k] + $urandom_range(0, 2) - 1,
                         centers_y[k] + $urandom_range(0, 2) - 1,
                         centers_z[k] + ($urandom_range(1) ? 1 : -1),
                         $urandom_range(0, 255));
                send(ACT_NORMAL, centers_x[k], centers_y[k], centers_z[k],
                     $urandom_range(0, 255));
            end
            else if (pick < 85)
            begin
                // border request: push one coordinate to 0 or 255
                case ($urandom_range(0, 2))
                    0: send(ACT_NORMAL, $urandom_range(1) ? 255 : 0,
                            $urandom_range(0, 255), $urandom_range(0, 255), 0);
                    1: send(ACT_NORMAL, $urandom_range(0, 255),
                            $urandom_range(1) ? 255 : 0, $urandom_range(0, 255), 0);
                    default: send(ACT_NORMAL, $urandom_range(0, 255),
                                  $urandom_range(0, 255), $urandom_range(1) ? 255 : 0,
                                  $urandom_range(0, 255));
                endcase
            end
            else
            begin
                send(ACT_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255));
                // an interior request on already-stored voxels, if any exists
                k = $urandom_range(0, centers_x.size() - 1);
                if (sb.ready(centers_x[k], centers_y[k], centers_z[k]))
                    send(ACT_NORMAL, centers_x[k], centers_y[k], centers_z[k], 0);
            end
        end

        @(negedge clk);
        start <= 1'b0;

        // Drain: the watchdog bounds this wait.
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.fails == 0 && sb.pending.size() == 0)
            $display("** volume_gradient_normal: PASSED **");
        else
            $display("** volume_gradient_normal: FAILED **");
        $finish;
    end
endmodule
